FILE: rtl/env_sensor_compensation_assert.svh
// Assertion macros for the compensation block
`ifndef ENV_SENSOR_COMPENSATION_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_ASSERT_SVH
`ifndef SYNTHESIS
`define ESC_ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication failed");
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define ESC_ASSERT_IMPLIES(lbl, clk, rst_n, a, b)
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/esc_pkg.sv
`timescale 1ns / 1ps
package esc_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [2:0] CFG_CAL_TEMP    = 3'd0;
    localparam logic [2:0] CFG_CAL_PRESS_A = 3'd1;
    localparam logic [2:0] CFG_CAL_PRESS_B = 3'd2;
    localparam logic [2:0] CFG_CAL_PRESS_C = 3'd3;
    localparam logic [2:0] CFG_CAL_HUM_A   = 3'd4;
    localparam logic [2:0] CFG_CAL_HUM_B   = 3'd5;

    localparam logic [31:0] HUM_MAX = 32'd419430400;

    typedef struct packed {
        logic [19:0] at;
        logic [19:0] ap;
        logic [15:0] ah;
    } t_raw;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] pa;
        logic [63:0] pb;
        logic [15:0] pc;
        logic [31:0] ha;
        logic [31:0] hb;
    } t_cal;

endpackage

FILE: rtl/esc_front.sv
`timescale 1ns / 1ps
module esc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  esc_pkg::t_raw i_raw,
    output logic          o_q_valid,
    input  logic          i_q_ready,
    output esc_pkg::t_raw o_q_raw
);

    esc_pkg::t_raw                  r_mem [esc_pkg::Q_DEPTH];
    logic [esc_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [esc_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [esc_pkg::Q_CNT_W-1:0]    r_count;
    logic                           push;
    logic                           pop;

    assign o_in_ready = (r_count != esc_pkg::Q_CNT_W'(esc_pkg::Q_DEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_raw    = r_mem[r_rd_ptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/esc_mul.sv
`timescale 1ns / 1ps
module esc_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);

    // a*b mod 2^64 from three 32x32 partial products
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_pp;
    logic [63:0] r_acc;
    logic [1:0]  r_ph;
    logic        r_busy;
    logic        r_done;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] pp_sh;

    always_comb begin
        unique case (r_ph)
            2'd1:    begin mx = r_a[31:0];  my = r_b[63:32]; end
            2'd2:    begin mx = r_a[63:32]; my = r_b[31:0];  end
            default: begin mx = r_a[31:0];  my = r_b[31:0];  end
        endcase
        pp_sh = (r_ph == 2'd1) ? r_pp : {r_pp[31:0], 32'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_pp <= mx * my;
            if (r_ph != 2'd0) begin
                r_acc <= r_acc + pp_sh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_ph == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= '0;
            end else if (r_busy) begin
                r_ph <= r_ph + 2'd1;
                if (r_ph == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: rtl/esc_div.sv
`timescale 1ns / 1ps
module esc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);

    // signed, truncating, one quotient bit a cycle
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_md;
    logic [63:0] r_q;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_fix;
    logic        r_done;
    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    logic        q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_quo[63]};
        rem_sub = rem_sh - {1'b0, r_md};
        q_bit   = !rem_sub[64];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num[63] ? (~i_num + 64'd1) : i_num;
            r_md  <= i_den[63] ? (~i_den + 64'd1) : i_den;
            r_neg <= i_num[63] ^ i_den[63];
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[63:0] : rem_sh[63:0];
            r_quo <= {r_quo[62:0], q_bit};
        end
        if (r_fix) begin
            r_q <= r_neg ? (~r_quo + 64'd1) : r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_fix  <= r_busy && (r_cnt == 6'd63);
            r_done <= r_fix;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

FILE: rtl/esc_back.sv
`timescale 1ns / 1ps
module esc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  esc_pkg::t_cal i_cal,
    input  logic          i_q_valid,
    output logic          o_q_ready,
    input  esc_pkg::t_raw i_q_raw,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [31:0]   o_temp_centi,
    output logic [31:0]   o_press_pa,
    output logic [16:0]   o_hum_q10
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ISSUE = 6'b000010,
        S_WAIT  = 6'b000100,
        S_DIV   = 6'b001000,
        S_DWAIT = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    typedef enum logic [4:0] {
        M_TV1 = 5'd0,  M_TBB = 5'd1,  M_TV2 = 5'd2,  M_TOUT = 5'd3,
        M_PXX = 5'd4,  M_PX2A = 5'd5, M_PX2B = 5'd6, M_PYA = 5'd7,
        M_PYB = 5'd8,  M_PD = 5'd9,   M_PNUM = 5'd10, M_PE = 5'd11,
        M_PQ1 = 5'd12, M_PQ2 = 5'd13, M_HU = 5'd14,  M_HG = 5'd15,
        M_HK = 5'd16,  M_HW = 5'd17,  M_HW2 = 5'd18, M_HR = 5'd19,
        M_HM = 5'd20,  M_HR2 = 5'd21
    } t_step;

    t_state        r_state;
    t_step         r_step;
    esc_pkg::t_raw r_raw;
    logic [31:0]   r_v1, r_c, r_tf, r_temp, r_u, r_g, r_k, r_w, r_r, r_m;
    logic [63:0]   r_xx, r_x2, r_y, r_d, r_num, r_p, r_e, r_q1;
    logic [31:0]   r_press;
    logic [16:0]   r_hum;
    logic          r_out_valid;
    logic [31:0]   r_o_temp;
    logic [31:0]   r_o_press;
    logic [16:0]   r_o_hum;

    logic          mul_start, mul_done, div_start, div_done;
    logic [63:0]   mul_a, mul_b, prod, quo;
    logic [31:0]   lo;
    logic [31:0]   t1, t2, t3, ta, tb, v, s;
    logic [31:0]   h1, h2, h3, h4, h5, h6;
    logic [63:0]   x1, n0, ps, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0]   pq2, psum, pf, pfs;
    logic [31:0]   r2, rc;
    logic          load_out;

    always_comb begin
        t1 = {16'b0, i_cal.temp[15:0]};
        t2 = 32'($signed(i_cal.temp[31:16]));
        t3 = 32'($signed(i_cal.temp[47:32]));
        ta = ({12'b0, r_raw.at} >> 3) - {t1[30:0], 1'b0};
        tb = ({12'b0, r_raw.at} >> 4) - t1;
        p1 = {48'b0, i_cal.pa[15:0]};
        p2 = 64'($signed(i_cal.pa[31:16]));
        p3 = 64'($signed(i_cal.pa[47:32]));
        p4 = 64'($signed(i_cal.pa[63:48]));
        p5 = 64'($signed(i_cal.pb[15:0]));
        p6 = 64'($signed(i_cal.pb[31:16]));
        p7 = 64'($signed(i_cal.pb[47:32]));
        p8 = 64'($signed(i_cal.pb[63:48]));
        p9 = 64'($signed(i_cal.pc));
        h1 = {24'b0, i_cal.ha[7:0]};
        h2 = 32'($signed(i_cal.ha[23:8]));
        h3 = {24'b0, i_cal.ha[31:24]};
        h4 = 32'($signed(i_cal.hb[11:0]));
        h5 = 32'($signed(i_cal.hb[23:12]));
        h6 = 32'($signed(i_cal.hb[31:24]));
        x1 = 64'($signed(r_tf)) - 64'd128000;
        n0 = ((64'd1048576 - {44'b0, r_raw.ap}) << 31) - r_x2;
        ps = $signed(r_p) >>> 13;
        v  = r_tf - 32'd76800;
        s  = $signed(r_r) >>> 15;
        lo = prod[31:0];
        pq2  = $signed(prod) >>> 19;
        psum = r_p + r_q1 + pq2;
        pf   = 64'($signed(psum) >>> 8) + (p7 << 4);
        pfs  = $signed(pf) >>> 8;
        r2   = r_r - 32'($signed(lo) >>> 4);
        if (r2[31]) begin
            rc = '0;
        end else if (r2 > esc_pkg::HUM_MAX) begin
            rc = esc_pkg::HUM_MAX;
        end else begin
            rc = r2;
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        unique case (r_step)
            M_TV1:   begin mul_a = {32'b0, ta};    mul_b = {32'b0, t2};  end
            M_TBB:   begin mul_a = {32'b0, tb};    mul_b = {32'b0, tb};  end
            M_TV2:   begin mul_a = {32'b0, r_c};   mul_b = {32'b0, t3};  end
            M_TOUT:  begin mul_a = {32'b0, r_tf};  mul_b = 64'd5;        end
            M_PXX:   begin mul_a = x1;             mul_b = x1;           end
            M_PX2A:  begin mul_a = r_xx;           mul_b = p6;           end
            M_PX2B:  begin mul_a = x1;             mul_b = p5;           end
            M_PYA:   begin mul_a = r_xx;           mul_b = p3;           end
            M_PYB:   begin mul_a = x1;             mul_b = p2;           end
            M_PD:    begin mul_a = r_y;            mul_b = p1;           end
            M_PNUM:  begin mul_a = n0;             mul_b = 64'd3125;     end
            M_PE:    begin mul_a = p9;             mul_b = ps;           end
            M_PQ1:   begin mul_a = r_e;            mul_b = ps;           end
            M_PQ2:   begin mul_a = p8;             mul_b = r_p;          end
            M_HU:    begin mul_a = {32'b0, h5};    mul_b = {32'b0, v};   end
            M_HG:    begin mul_a = {32'b0, v};     mul_b = {32'b0, h6};  end
            M_HK:    begin mul_a = {32'b0, v};     mul_b = {32'b0, h3};  end
            M_HW:    begin mul_a = {32'b0, r_g};   mul_b = {32'b0, r_k}; end
            M_HW2:   begin mul_a = {32'b0, r_w};   mul_b = {32'b0, h2};  end
            M_HR:    begin mul_a = {32'b0, r_u};   mul_b = {32'b0, r_w}; end
            M_HM:    begin mul_a = {32'b0, s};     mul_b = {32'b0, s};   end
            M_HR2:   begin mul_a = {32'b0, r_m};   mul_b = {32'b0, h1};  end
            default: begin mul_a = '0;             mul_b = '0;           end
        endcase
    end

    assign mul_start = (r_state == S_ISSUE);
    assign div_start = (r_state == S_DIV);
    assign o_q_ready = (r_state == S_IDLE);
    assign load_out  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    esc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_d),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid) begin
            r_raw <= i_q_raw;
        end
        if (r_state == S_DWAIT && div_done) begin
            r_p <= quo;
        end
        if (r_state == S_WAIT && mul_done) begin
            unique case (r_step)
                M_TV1:   r_v1 <= $signed(lo) >>> 11;
                M_TBB:   r_c <= $signed(lo) >>> 12;
                M_TV2:   r_tf <= r_v1 + 32'($signed(lo) >>> 14);
                M_TOUT:  r_temp <= $signed(lo + 32'd128) >>> 8;
                M_PXX:   r_xx <= prod;
                M_PX2A:  r_x2 <= prod;
                M_PX2B:  r_x2 <= r_x2 + (prod << 17) + (p4 << 35);
                M_PYA:   r_y <= $signed(prod) >>> 8;
                M_PYB:   r_y <= (64'd1 << 47) + r_y + (prod << 12);
                M_PD:    r_d <= $signed(prod) >>> 33;
                M_PNUM:  r_num <= prod;
                M_PE:    r_e <= prod;
                M_PQ1:   r_q1 <= $signed(prod) >>> 25;
                M_PQ2:   r_press <= (r_d == '0) ? 32'd0 : pfs[31:0];
                M_HU:    r_u <= $signed(({2'b0, r_raw.ah, 14'b0}) - (h4 << 20) - lo
                                        + 32'd16384) >>> 15;
                M_HG:    r_g <= $signed(lo) >>> 10;
                M_HK:    r_k <= 32'($signed(lo) >>> 11) + 32'd32768;
                M_HW:    r_w <= 32'($signed(lo) >>> 10) + 32'd2097152;
                M_HW2:   r_w <= $signed(lo + 32'd8192) >>> 14;
                M_HR:    r_r <= lo;
                M_HM:    r_m <= $signed(lo) >>> 7;
                M_HR2:   r_hum <= rc[28:12];
                default: r_m <= r_m;
            endcase
        end
        if (load_out) begin
            r_o_temp  <= r_temp;
            r_o_press <= r_press;
            r_o_hum   <= r_hum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= M_TV1;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_step  <= M_TV1;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (mul_done) begin
                        if (r_step == M_PNUM) begin
                            r_state <= S_DIV;
                        end else if (r_step == M_HR2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_step  <= t_step'(r_step + 5'd1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_DIV: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_done) begin
                        r_step  <= M_PE;
                        r_state <= S_ISSUE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_temp_centi = r_o_temp;
    assign o_press_pa   = r_o_press;
    assign o_hum_q10    = r_o_hum;

endmodule

FILE: rtl/env_sensor_compensation.sv
`timescale 1ns / 1ps
// Channel   Handshake                   Word
// input     i_in_valid / o_in_ready     i_raw_temp, i_raw_press, i_raw_hum
// output    o_out_valid / i_out_ready   o_temp_centi, o_press_pa, o_hum_q10
// config    i_cfg_wr_en (no wait)       i_cfg_idx, i_cfg_data
//
// Per word: 22 products through one shared 32x32 multiplier (three partial
// products each) and one division by a radix-2 64-bit divider. A two-word
// queue takes input while the back end works and while a finished result
// waits at the output register.
// Synchronous active-low reset clears the queue, sequencer and calibration.
module env_sensor_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [19:0] i_raw_temp,
    input  logic [19:0] i_raw_press,
    input  logic [15:0] i_raw_hum,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_temp_centi,
    output logic [31:0] o_press_pa,
    output logic [16:0] o_hum_q10
);

`include "env_sensor_compensation_assert.svh"

    esc_pkg::t_cal r_cal;
    esc_pkg::t_raw in_raw;
    esc_pkg::t_raw q_raw;
    logic          q_valid;
    logic          q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                esc_pkg::CFG_CAL_TEMP:    r_cal.temp <= i_cfg_data[47:0];
                esc_pkg::CFG_CAL_PRESS_A: r_cal.pa   <= i_cfg_data;
                esc_pkg::CFG_CAL_PRESS_B: r_cal.pb   <= i_cfg_data;
                esc_pkg::CFG_CAL_PRESS_C: r_cal.pc   <= i_cfg_data[15:0];
                esc_pkg::CFG_CAL_HUM_A:   r_cal.ha   <= i_cfg_data[31:0];
                esc_pkg::CFG_CAL_HUM_B:   r_cal.hb   <= i_cfg_data[31:0];
                default:                  r_cal      <= r_cal;
            endcase
        end
    end

    assign in_raw = '{at: i_raw_temp, ap: i_raw_press, ah: i_raw_hum};

    esc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_raw      (in_raw),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_raw    (q_raw)
    );

    esc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cal        (r_cal),
        .i_q_valid    (q_valid),
        .o_q_ready    (q_ready),
        .i_q_raw      (q_raw),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_temp_centi (o_temp_centi),
        .o_press_pa   (o_press_pa),
        .o_hum_q10    (o_hum_q10)
    );

    // a full queue always has a word for the back end
    `ESC_ASSERT_IMPLIES(a_full_has_word, i_clk, i_rst_n, !o_in_ready, q_valid)
    // clamped humidity never exceeds 100 %RH
    `ESC_ASSERT_IMPLIES(a_hum_range, i_clk, i_rst_n, o_out_valid, o_hum_q10 <= 17'd102400)
    // the back end takes a word only when it is free of one
    `ESC_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, q_valid && q_ready, !q_ready)

endmodule
